FILE: sv/sorted_value_table_defines.svh
// ----------------------------------------------------------------------------
// sorted value table assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_TABLE_DEFINES_SVH
`define SORTED_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/svt_pkg.sv
// ----------------------------------------------------------------------------
// sorted value table package
// operation and status codes, controller states and control structs
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam int VALUE_W = 32;
	localparam int FIELD_W = 5;
	localparam int FIELD_MAX = 31;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_COUNT  = 2'd2;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_NOMATCH = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_EXEC,
		S_INS_STEP,
		S_INS_WR,
		S_DEL_STEP,
		S_DEL_WR,
		S_DONE
	} svt_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_EXEC,
		OP_INS_STEP,
		OP_INS_WR,
		OP_DEL_STEP,
		OP_DEL_WR,
		OP_OUT
	} svt_op_t;

	typedef struct packed {
		svt_op_t op;
	} svt_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic ins_pos;
		logic del_end;
		logic do_ins;
		logic do_del;
	} svt_stat_t;

endpackage

FILE: sv/svt_req_if.sv
// ----------------------------------------------------------------------------
// sorted value table request channel
// valid/ready channel carrying one operation and its operand
// ----------------------------------------------------------------------------
interface svt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

FILE: sv/svt_rsp_if.sv
// ----------------------------------------------------------------------------
// sorted value table response channel
// valid/ready channel carrying one result per operation
// ----------------------------------------------------------------------------
interface svt_rsp_if;
	logic       valid;
	logic       ready;
	logic [4:0] match_count;
	logic [1:0] status;
	logic [4:0] occupancy;

	modport source (output valid, output match_count, output status, output occupancy,
		input ready);
	modport sink (input valid, input match_count, input status, input occupancy,
		output ready);
endinterface

FILE: sv/svt_datapath.sv
// ----------------------------------------------------------------------------
// sorted value table datapath
// value memory, scan counters, shift addressing and result register
// ----------------------------------------------------------------------------
`include "sorted_value_table_defines.svh"

module svt_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  svt_pkg::svt_cmd_t  cmd,
	output svt_pkg::svt_stat_t stat,
	input  logic [1:0]         req_kind,
	input  logic signed [31:0] req_value,
	output logic [4:0]         rsp_match_count,
	output logic [1:0]         rsp_status,
	output logic [4:0]         rsp_occupancy
);
	import svt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic signed [VALUE_W-1:0] mem [CAPACITY];
	logic signed [VALUE_W-1:0] rd_data_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [1:0]                kind_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             copies_q;
	logic [CW-1:0]             first_ge_q;
	logic                      ge_found_q;
	logic [1:0]                status_q;
	logic [FIELD_W-1:0]        match_out_q;
	logic [1:0]                status_out_q;
	logic [FIELD_W-1:0]        occ_out_q;

	logic [CW-1:0]             idx_dec;
	logic [CW-1:0]             idx_inc;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic signed [VALUE_W-1:0] wr_data;
	logic [31:0]               copies_w;
	logic [31:0]               cnt_w;

	assign idx_dec = idx_q - ONE_C;
	assign idx_inc = idx_q + ONE_C;

	assign stat.scan_end = (idx_q == cnt_q);
	assign stat.ins_pos  = (idx_q == first_ge_q);
	assign stat.del_end  = (idx_inc == cnt_q);
	assign stat.do_ins   = (kind_q == KIND_INSERT) && (cnt_q != CAP_C);
	assign stat.do_del   = (kind_q == KIND_DELETE) && (copies_q != '0);

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_data_q;
		case (cmd.op)
			OP_SCAN_RD: begin
				rd_en = !stat.scan_end;
			end
			OP_INS_STEP: begin
				if (stat.ins_pos) begin
					wr_en   = 1'b1;
					wr_data = value_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_dec[AW-1:0];
				end
			end
			OP_INS_WR: begin
				wr_en = 1'b1;
			end
			OP_DEL_STEP: begin
				if (!stat.del_end) begin
					rd_en   = 1'b1;
					rd_addr = idx_inc[AW-1:0];
				end
			end
			OP_DEL_WR: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// counts saturate at the field limit
	assign copies_w = 32'(copies_q);
	assign cnt_w    = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					idx_q <= '0;
				end
				OP_SCAN_CMP: begin
					idx_q <= idx_inc;
				end
				OP_EXEC: begin
					if (stat.do_ins) begin
						idx_q <= cnt_q;
					end else if (stat.do_del) begin
						idx_q <= first_ge_q;
					end
				end
				OP_INS_STEP: begin
					if (stat.ins_pos) begin
						cnt_q <= cnt_q + ONE_C;
					end
				end
				OP_INS_WR: begin
					idx_q <= idx_dec;
				end
				OP_DEL_STEP: begin
					if (stat.del_end) begin
						cnt_q <= cnt_q - ONE_C;
					end
				end
				OP_DEL_WR: begin
					idx_q <= idx_inc;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q     <= req_kind;
				value_q    <= req_value;
				copies_q   <= '0;
				first_ge_q <= cnt_q;
				ge_found_q <= 1'b0;
			end
			OP_SCAN_CMP: begin
				if (rd_data_q == value_q) begin
					copies_q <= copies_q + ONE_C;
				end
				// first entry not below the operand
				if (!ge_found_q && !(rd_data_q < value_q)) begin
					first_ge_q <= idx_q;
					ge_found_q <= 1'b1;
				end
			end
			OP_EXEC: begin
				if (stat.do_ins || stat.do_del) begin
					status_q <= STATUS_DONE;
				end else if (kind_q == KIND_INSERT) begin
					status_q <= STATUS_FULL;
				end else if (kind_q == KIND_DELETE) begin
					status_q <= STATUS_NOMATCH;
				end else begin
					status_q <= STATUS_DONE;
				end
			end
			OP_OUT: begin
				match_out_q  <= (copies_w > 32'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
					: copies_w[FIELD_W-1:0];
				status_out_q <= status_q;
				occ_out_q    <= (cnt_w > 32'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
					: cnt_w[FIELD_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign rsp_match_count = match_out_q;
	assign rsp_status      = status_out_q;
	assign rsp_occupancy   = occ_out_q;

	`SVT_ASSERT_NOW(a_fill_in_range, 1'b1, cnt_q <= CAP_C, "fill level above capacity")
	`SVT_ASSERT_NOW(a_idx_in_range, 1'b1, idx_q <= cnt_q, "index beyond fill level")
	`SVT_ASSERT_NOW(a_ins_not_full, (cmd.op == OP_INS_STEP) && stat.ins_pos,
		cnt_q < CAP_C, "insert write into a full table")

endmodule

FILE: sv/svt_controller.sv
// ----------------------------------------------------------------------------
// sorted value table controller
// sequences scan, insert shift, delete shift and result handoff
// ----------------------------------------------------------------------------
`include "sorted_value_table_defines.svh"

module svt_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output svt_pkg::svt_cmd_t  cmd,
	input  svt_pkg::svt_stat_t stat
);
	import svt_pkg::*;

	svt_state_t state_q;
	svt_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = stat.scan_end ? S_EXEC : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = S_SCAN_RD;
			end
			S_EXEC: begin
				if (stat.do_ins) begin
					state_d = S_INS_STEP;
				end else if (stat.do_del) begin
					state_d = S_DEL_STEP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INS_STEP: begin
				state_d = stat.ins_pos ? S_DONE : S_INS_WR;
			end
			S_INS_WR: begin
				state_d = S_INS_STEP;
			end
			S_DEL_STEP: begin
				state_d = stat.del_end ? S_DONE : S_DEL_WR;
			end
			S_DEL_WR: begin
				state_d = S_DEL_STEP;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_SCAN_RD:  cmd.op = OP_SCAN_RD;
			S_SCAN_CMP: cmd.op = OP_SCAN_CMP;
			S_EXEC:     cmd.op = OP_EXEC;
			S_INS_STEP: cmd.op = OP_INS_STEP;
			S_INS_WR:   cmd.op = OP_INS_WR;
			S_DEL_STEP: cmd.op = OP_DEL_STEP;
			S_DEL_WR:   cmd.op = OP_DEL_WR;
			S_DONE: begin
				if (slot_free) begin
					cmd.op = OP_OUT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	`SVT_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q == S_DONE),
		"result raised outside the done state")
	`SVT_ASSERT_NEXT(a_done_completes, (state_q == S_DONE) && !out_valid_q,
		out_valid_q && (state_q == S_IDLE), "done state did not hand off result")
	`SVT_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_q == S_SCAN_RD,
		"accepted request did not start a scan")

endmodule

FILE: sv/sorted_value_table.sv
// ----------------------------------------------------------------------------
// sorted value table
// ascending table of signed values with insert, delete-one and count
// ----------------------------------------------------------------------------
//
//  channel    dir  payload                              transfer
//  request    in   kind[1:0], value[31:0] signed        valid & ready
//  response   out  match_count[4:0], status[1:0],       valid & ready
//                  occupancy[4:0]
//
//  each operation: a scan that reads and compares every stored value, a decide
//    step, a shift for an insert or a delete that goes ahead, then the result handoff
//    insert moves the entries from the insertion point up; delete moves the entries
//    after the first match down; the value memory does one registered read or one write per step
//  reset: fill level cleared at once, no clearing pass; the memory is never read
//    above the fill level
//  a new request is taken while the previous result waits in the output register;
//    a stalled response holds the next result in the done state
//
module sorted_value_table #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	svt_req_if.sink    request,
	svt_rsp_if.source  response
);
	import svt_pkg::*;

	svt_cmd_t  cmd;
	svt_stat_t stat;
	logic      ready_w;
	logic      valid_w;

	// sequencer: one state per memory step
	svt_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (ready_w),
		.rsp_valid (valid_w),
		.rsp_ready (response.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// memory, scan registers and result register
	svt_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_kind        (request.kind),
		.req_value       (request.value),
		.rsp_match_count (response.match_count),
		.rsp_status      (response.status),
		.rsp_occupancy   (response.occupancy)
	);

	// handshake outputs
	assign request.ready  = ready_w;
	assign response.valid = valid_w;

endmodule

FILE: test/svt_table_checker.sv
// ----------------------------------------------------------------------------
// sorted value table checker
// keeps a shadow copy of the sorted table, predicts one result per request
// transfer and compares every response transfer against the oldest prediction
// ----------------------------------------------------------------------------
module svt_table_checker #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	svt_req_if   request,
	svt_rsp_if   response,
	output int   fail_count,
	output int   outstanding
);
	import svt_pkg::*;

	localparam int REPORT_CAP = 64;

	typedef struct packed {
		logic [FIELD_W-1:0] match_count;
		logic [1:0]         status;
		logic [FIELD_W-1:0] occupancy;
	} table_result_t;

	logic signed [VALUE_W-1:0] shadow_values [CAPACITY];
	int                        shadow_fill;
	table_result_t             predicted_results [$];

	function automatic logic [FIELD_W-1:0] sat_field(input int v);
		return (v > FIELD_MAX) ? FIELD_W'(FIELD_MAX) : FIELD_W'(v);
	endfunction

	// updates the shadow table and returns the result the block owes
	function automatic table_result_t apply_operation(input logic [1:0] kind,
			input logic signed [VALUE_W-1:0] value);
		int            copies;
		int            first_ge;
		int            first_eq;
		int            n;
		logic [1:0]    st;
		table_result_t res;
		n        = shadow_fill;
		copies   = 0;
		first_ge = n;
		first_eq = n;
		st       = STATUS_DONE;
		for (int i = 0; i < n; i++) begin
			if (shadow_values[i] == value) begin
				copies++;
				if (first_eq == n)
					first_eq = i;
			end
			if (first_ge == n && shadow_values[i] >= value)
				first_ge = i;
		end
		if (kind == KIND_INSERT) begin
			if (n >= CAPACITY) begin
				st = STATUS_FULL;
			end else begin
				for (int i = n; i > first_ge; i--)
					shadow_values[i] = shadow_values[i - 1];
				shadow_values[first_ge] = value;
				n++;
			end
		end else if (kind == KIND_DELETE) begin
			if (copies == 0) begin
				st = STATUS_NOMATCH;
			end else begin
				for (int i = first_eq; i + 1 < n; i++)
					shadow_values[i] = shadow_values[i + 1];
				n--;
			end
		end
		// any other kind only counts
		shadow_fill     = n;
		res.match_count = sat_field(copies);
		res.status      = st;
		res.occupancy   = sat_field(n);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t got;
		table_result_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			predicted_results.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (response.valid && response.ready) begin
				got.match_count = response.match_count;
				got.status      = response.status;
				got.occupancy   = response.occupancy;
				if (predicted_results.size() == 0) begin
					if (fail_count < REPORT_CAP)
						$display("%0t: unexpected result count %0d status %0d occupancy %0d",
							$time, got.match_count, got.status, got.occupancy);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (got !== want) begin
						if (fail_count < REPORT_CAP)
							$display({"%0t: mismatch expected count %0d status %0d ",
								"occupancy %0d, got count %0d status %0d occupancy %0d"},
								$time, want.match_count, want.status, want.occupancy,
								got.match_count, got.status, got.occupancy);
						fail_count++;
					end
				end
			end
			if (request.valid && request.ready)
				predicted_results.push_back(apply_operation(request.kind, request.value));
			outstanding = predicted_results.size();
		end
	end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// sorted value table testbench
// directed corner operations followed by random insert/delete/count/unused-kind traffic
// with random gaps on both channels; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module tb;
	import svt_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int RANDOM_OPS  = 1925;
	localparam int STALL_LIMIT = 2000;   // cycles with no transfer at all
	localparam int DRAIN_WAIT  = 100;
	localparam int MAX_GAP     = 17;

	// the request kind the block treats like a count
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   idle_cycles;

	// sender pacing state
	int   send_run_left;
	bit   send_eager;

	svt_req_if request ();
	svt_rsp_if response ();

	sorted_value_table #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response)
	);

	svt_table_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.response    (response),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// gap before the next transfer; eager stretches have no gaps at all so
	// back-to-back traffic is exercised as well as sparse traffic
	function automatic int draw_gap(inout int run_left, inout bit eager);
		if (run_left == 0) begin
			eager    = ($urandom_range(0, 2) == 0);
			run_left = $urandom_range(10, 60);
		end
		run_left--;
		return eager ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// one request transfer; valid stays high into the next item when it
	// has no gap, so valid is never dropped and raised in one step
	task automatic send_op(input logic [1:0] kind, input logic signed [31:0] value);
		int gap;
		gap = draw_gap(send_run_left, send_eager);
		if (gap > 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request.valid <= 1'b1;
		request.kind  <= kind;
		request.value <= value;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
	endtask

	// operand: mostly a small pool so deletes and counts find matches,
	// sometimes an extreme, sometimes any 32-bit pattern
	function automatic logic signed [31:0] pick_operand();
		int r;
		r = $urandom_range(0, 15);
		if (r < 11)
			return $signed($urandom_range(0, 9)) - 5;
		if (r < 13) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MIN + 1;
				2: return VAL_MAX - 1;
				default: return VAL_MAX;
			endcase
		end
		return $signed($urandom);
	endfunction

	// response side: random stall before each result, ready held until it arrives
	initial begin
		int  gap;
		int  run_left;
		bit  eager;
		response.ready = 1'b0;
		run_left = 0;
		eager    = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(run_left, eager);
			if (gap > 0) begin
				response.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			response.ready <= 1'b1;
			@(posedge clk);
			while (!response.valid)
				@(posedge clk);
		end
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (request.valid && request.ready) ||
				(response.valid && response.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int         r;
		int         insert_pct;
		int         delete_pct;
		logic [1:0] kind;
		// every input known from time zero
		arst_n        = 1'b0;
		request.valid = 1'b0;
		request.kind  = KIND_INSERT;
		request.value = '0;
		send_run_left = 0;
		send_eager    = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: count, delete with no match, unused kind
		send_op(KIND_COUNT, 32'sd0);
		send_op(KIND_DELETE, 32'sd7);
		send_op(KIND_UNUSED, 32'sd0);

		// fill to capacity: extremes, duplicates at both ends and in the middle
		send_op(KIND_INSERT, VAL_MAX);
		send_op(KIND_INSERT, VAL_MIN);
		send_op(KIND_INSERT, 32'sd0);
		send_op(KIND_INSERT, -32'sd1);
		send_op(KIND_INSERT, 32'sd5);
		send_op(KIND_INSERT, 32'sd5);
		send_op(KIND_INSERT, 32'sd5);
		send_op(KIND_INSERT, 32'sd3);
		send_op(KIND_INSERT, 32'sd7);
		send_op(KIND_INSERT, -32'sd100);
		send_op(KIND_INSERT, 32'sd100);
		send_op(KIND_INSERT, VAL_MIN);
		send_op(KIND_INSERT, VAL_MAX);
		send_op(KIND_INSERT, 32'sd1);
		send_op(KIND_INSERT, 32'sd2);
		send_op(KIND_INSERT, 32'sd4);

		// full table drops the insert, then counts and deletes of duplicates and a delete with no match
		send_op(KIND_INSERT, 32'sd6);
		send_op(KIND_COUNT, 32'sd5);
		send_op(KIND_UNUSED, 32'sd5);
		send_op(KIND_DELETE, 32'sd5);
		send_op(KIND_DELETE, 32'sd42);
		send_op(KIND_DELETE, VAL_MIN);
		send_op(KIND_COUNT, VAL_MIN);

		// random traffic in phases that fill, drain or churn the table
		insert_pct = 40;
		delete_pct = 35;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 48 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						insert_pct = 70;
						delete_pct = 15;
					end
					1: begin
						insert_pct = 20;
						delete_pct = 60;
					end
					default: begin
						insert_pct = 40;
						delete_pct = 35;
					end
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				kind = KIND_UNUSED;
			else if (r < 3 + insert_pct)
				kind = KIND_INSERT;
			else if (r < 3 + insert_pct + delete_pct)
				kind = KIND_DELETE;
			else
				kind = KIND_COUNT;
			send_op(kind, pick_operand());
		end
		request.valid <= 1'b0;

		// drain, then give the block time to show any stray result
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sorted_value_table.f
+incdir+sv
sv/svt_pkg.sv
sv/svt_req_if.sv
sv/svt_rsp_if.sv
sv/svt_datapath.sv
sv/svt_controller.sv
sv/sorted_value_table.sv
test/svt_table_checker.sv
test/tb.sv
